[rtl/sds_pkg.sv]
`default_nettype none

package sds_pkg;

  localparam int CAPACITY = 8;
  localparam int STAGE_W  = 32;
  localparam int PHASE_W  = 2;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_DRAIN  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     merge;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sds_if.sv]
`default_nettype none

interface sds_req_if
  import sds_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               func;
  logic [STAGE_W-1:0] stage_id;
  logic [PHASE_W-1:0] dep_phase;

  modport source (output valid, output func, output stage_id, output dep_phase,
                  input ready);
  modport sink (input valid, input func, input stage_id, input dep_phase,
                output ready);
endinterface

interface sds_rsp_if
  import sds_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               entry_valid;
  logic [STAGE_W-1:0] out_stage;
  logic [PHASE_W-1:0] out_phase;
  logic               last;

  modport source (output valid, output accepted, output entry_valid,
                  output out_stage, output out_phase, output last, input ready);
  modport sink (input valid, input accepted, input entry_valid,
                input out_stage, input out_phase, input last, output ready);
endinterface

`default_nettype wire

[rtl/sds_cell.sv]
`default_nettype none

module sds_cell
  import sds_pkg::*;
(
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic               occupied,
  input  wire logic               left_lt,
  input  wire logic [STAGE_W-1:0] new_stage,
  input  wire logic [PHASE_W-1:0] new_phase,
  input  wire logic [STAGE_W-1:0] left_stage,
  input  wire logic [PHASE_W-1:0] left_phase,
  input  wire logic [STAGE_W-1:0] right_stage,
  input  wire logic [PHASE_W-1:0] right_phase,
  output logic [STAGE_W-1:0]      stage,
  output logic [PHASE_W-1:0]      phase,
  output logic                    lt,
  output logic                    eq
);

  assign lt = occupied && (stage < new_stage);
  assign eq = occupied && (stage == new_stage);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_APPEND: begin
        if (ctl.merge) begin
          if (eq && (new_phase > phase)) begin
            phase <= new_phase;
          end
        end else if (!lt) begin
          if (left_lt) begin
            stage <= new_stage;
            phase <= new_phase;
          end else begin
            stage <= left_stage;
            phase <= left_phase;
          end
        end
      end
      CELL_SHIFT: begin
        stage <= right_stage;
        phase <= right_phase;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/sorted_dependency_set.sv]
// Sorted dependency set: up to CAPACITY (stage, phase) entries in ascending
// stage order, held in a chain of cells that compare in parallel.
// Request channel (req): func selects append or drain; stage_id and
// dep_phase carry the entry to append.
// Response channel (rsp): one response per append (accepted, last = 1);
// a drain gives one response per stored entry in order, last on the final
// one, or a single response with entry_valid = 0 when the set is empty.
// An append or an empty drain has its response registered in the cycle after
// the request is taken. A drain first sets the draining flag, then moves one
// entry per cycle from cell 0 to the output register while the receiver does
// not stall. Appends are taken one per cycle while the output register is
// free; no request is taken until the last response of a drain is registered.
// Outside a drain, the output register frees the request side when it is
// empty or rsp.ready is high; while the receiver stalls, req.ready is low and
// the chain holds. Reset empties the set; entry contents are not cleared.
`default_nettype none

module sorted_dependency_set
  import sds_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sds_req_if.sink   req,
  sds_rsp_if.source rsp
);

  logic [COUNT_W-1:0] count;
  logic               draining;

  cell_ctl_t          ctl;
  logic               out_free;
  logic               take;
  logic               append_take;
  logic               drain_step;
  logic               merge_hit;
  logic               has_room;

  logic [STAGE_W-1:0] cell_stage [CAPACITY];
  logic [PHASE_W-1:0] cell_phase [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  assign out_free    = !rsp.valid || rsp.ready;
  assign req.ready   = !draining && out_free;
  assign take        = req.valid && req.ready;
  assign append_take = take && (req.func == FUNC_APPEND);
  assign drain_step  = draining && out_free;
  assign merge_hit   = |cell_eq;
  assign has_room    = count < COUNT_W'(CAPACITY);

  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.merge = merge_hit;
    if (append_take && (merge_hit || has_room)) begin
      ctl.op = CELL_APPEND;
    end else if (drain_step) begin
      ctl.op = CELL_SHIFT;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_lt;
    logic [STAGE_W-1:0] left_stage;
    logic [PHASE_W-1:0] left_phase;
    logic [STAGE_W-1:0] right_stage;
    logic [PHASE_W-1:0] right_phase;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_stage = '0;
      assign left_phase = '0;
    end else begin : g_body
      assign left_lt    = cell_lt[i-1];
      assign left_stage = cell_stage[i-1];
      assign left_phase = cell_phase[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_stage = '0;
      assign right_phase = '0;
    end else begin : g_inner
      assign right_stage = cell_stage[i+1];
      assign right_phase = cell_phase[i+1];
    end

    sds_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (COUNT_W'(i) < count),
      .left_lt    (left_lt),
      .new_stage  (req.stage_id),
      .new_phase  (req.dep_phase),
      .left_stage (left_stage),
      .left_phase (left_phase),
      .right_stage(right_stage),
      .right_phase(right_phase),
      .stage      (cell_stage[i]),
      .phase      (cell_phase[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      draining  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (append_take) begin
        rsp.valid       <= 1'b1;
        rsp.accepted    <= merge_hit || has_room;
        rsp.entry_valid <= 1'b0;
        rsp.out_stage   <= '0;
        rsp.out_phase   <= '0;
        rsp.last        <= 1'b1;
        if (!merge_hit && has_room) begin
          count <= count + COUNT_W'(1);
        end
      end else if (take) begin
        if (count == '0) begin
          rsp.valid       <= 1'b1;
          rsp.accepted    <= 1'b0;
          rsp.entry_valid <= 1'b0;
          rsp.out_stage   <= '0;
          rsp.out_phase   <= '0;
          rsp.last        <= 1'b1;
        end else begin
          rsp.valid <= 1'b0;
          draining  <= 1'b1;
        end
      end else if (drain_step) begin
        rsp.valid       <= 1'b1;
        rsp.accepted    <= 1'b0;
        rsp.entry_valid <= 1'b1;
        rsp.out_stage   <= cell_stage[0];
        rsp.out_phase   <= cell_phase[0];
        rsp.last        <= (count == COUNT_W'(1));
        count           <= count - COUNT_W'(1);
        if (count == COUNT_W'(1)) begin
          draining <= 1'b0;
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
